>>> hw/rtl/tes_pkg.sv
// shared types, constants and helpers of the text encoding sniffer
package tes_pkg;

  // verdict codes
  typedef enum logic [3:0] {
    ENC_ANSI    = 4'd0,
    ENC_WIN1252 = 4'd1,
    ENC_UTF8    = 4'd2,
    ENC_UTF16BE = 4'd3,
    ENC_UTF16LE = 4'd4,
    ENC_UTF32BE = 4'd5,
    ENC_UTF32LE = 4'd6,
    ENC_SCSU    = 4'd7,
    ENC_BOCU1   = 4'd8
  } enc_e;

  // allowed range of the next continuation byte
  typedef enum logic [2:0] {
    RNG_ANY = 3'd0,  // 80..bf
    RNG_E0  = 3'd1,  // a0..bf
    RNG_ED  = 3'd2,  // 80..9f
    RNG_F0  = 3'd3,  // 90..bf
    RNG_F4  = 3'd4   // 80..8f
  } rng_e;

  typedef struct packed {
    logic [1:0] cont_left;
    rng_e       rng;
    logic       ok;
    logic       nul_stop;
  } utf8_st_t;

  localparam utf8_st_t U8_RESET = '{cont_left: 2'd0, rng: RNG_ANY, ok: 1'b1, nul_stop: 1'b0};

  localparam int unsigned LEAD_BYTES = 4;
  localparam logic [2:0]  SEEN_MAX   = 3'd4;

  // byte order marks, first byte in the low bits
  localparam logic [31:0] MARK_UTF8    = 32'h00bf_bbef;
  localparam logic [31:0] MARK_UTF16BE = 32'h0000_fffe;
  localparam logic [31:0] MARK_UTF32BE = 32'hfffe_0000;
  localparam logic [31:0] MARK_UTF32LE = 32'h0000_feff;
  localparam logic [31:0] MARK_UTF16LE = 32'h0000_feff;
  localparam logic [31:0] MARK_SCSU    = 32'h00ff_fe0e;
  localparam logic [31:0] MARK_BOCU1   = 32'h0028_eefb;

  localparam logic [2:0] BOM_NONE = 3'd0;
  localparam logic [2:0] BOM_LEN2 = 3'd2;
  localparam logic [2:0] BOM_LEN3 = 3'd3;
  localparam logic [2:0] BOM_LEN4 = 3'd4;

  // true when the buffer holds at least len bytes and starts with the mark
  function automatic logic mark_match(input logic [31:0] lead, input logic [2:0] seen,
                                      input logic [31:0] mark, input logic [2:0] len);
    logic hit;
    hit = (seen >= len);
    for (int i = 0; i < LEAD_BYTES; i++) begin
      if ((3'(i) < len) && (lead[8*i +: 8] != mark[8*i +: 8])) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

endpackage

>>> hw/rtl/tes_if.sv
// word channels of the text encoding sniffer: byte input and verdict output
interface tes_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface tes_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] encoding;
  logic [2:0] bom_length;

  modport source (output valid, output encoding, output bom_length, input ready);
  modport sink   (input valid, input encoding, input bom_length, output ready);
endinterface

>>> hw/rtl/tes_utf8_check.sv
// one byte step of the strict utf-8 well-formedness check
module tes_utf8_check import tes_pkg::*; (
  input  utf8_st_t   st_i,
  input  logic [7:0] byte_i,
  output utf8_st_t   st_o
);

  logic [7:0] lo;
  logic [7:0] hi;

  always_comb begin
    lo = 8'h80;
    hi = 8'hbf;
    case (st_i.rng)
      RNG_E0:  lo = 8'ha0;
      RNG_ED:  hi = 8'h9f;
      RNG_F0:  lo = 8'h90;
      RNG_F4:  hi = 8'h8f;
      default: ;
    endcase
  end

  always_comb begin
    st_o = st_i;
    if (st_i.ok && !st_i.nul_stop) begin
      if (st_i.cont_left != 2'd0) begin
        if ((byte_i < lo) || (byte_i > hi)) begin
          st_o.ok = 1'b0;
        end else begin
          st_o.cont_left = st_i.cont_left - 2'd1;
          st_o.rng       = RNG_ANY;
        end
      end else begin
        st_o.rng = RNG_ANY;
        if (byte_i == 8'h00) begin
          st_o.nul_stop = 1'b1;
        end else if ((byte_i == 8'h09) || (byte_i == 8'h0a) || (byte_i == 8'h0d) ||
                     ((byte_i >= 8'h20) && (byte_i <= 8'h7e))) begin
          // plain ascii
        end else if ((byte_i >= 8'hc2) && (byte_i <= 8'hdf)) begin
          st_o.cont_left = 2'd1;
        end else if (byte_i == 8'he0) begin
          st_o.cont_left = 2'd2;
          st_o.rng       = RNG_E0;
        end else if (((byte_i >= 8'he1) && (byte_i <= 8'hec)) ||
                     (byte_i == 8'hee) || (byte_i == 8'hef)) begin
          st_o.cont_left = 2'd2;
        end else if (byte_i == 8'hed) begin
          st_o.cont_left = 2'd2;
          st_o.rng       = RNG_ED;
        end else if (byte_i == 8'hf0) begin
          st_o.cont_left = 2'd3;
          st_o.rng       = RNG_F0;
        end else if ((byte_i >= 8'hf1) && (byte_i <= 8'hf3)) begin
          st_o.cont_left = 2'd3;
        end else if (byte_i == 8'hf4) begin
          st_o.cont_left = 2'd3;
          st_o.rng       = RNG_F4;
        end else begin
          st_o.ok = 1'b0;
        end
      end
    end
  end

endmodule

>>> hw/rtl/text_encoding_sniffer.sv
// text encoding sniffer: one verdict per buffer, byte order mark first, then utf-8 check
// path: the last byte is held in the input register, then loads the verdict register
// as soon as that register is empty or its verdict is being taken by the sink
// throughput: one byte per cycle, set by the single input register and verdict register,
// while no last byte waits for the verdict register, even while a verdict waits for the sink
// reset: async active low, clears valids and the per-buffer state to an empty buffer
module text_encoding_sniffer import tes_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  tes_in_if.sink    in_i,
  tes_out_if.source out_o
);

  // input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       in_acc;
  logic       s1_adv;
  logic       out_free;

  // per-buffer state
  logic [31:0] lead_q, lead_d, lead_nx;
  logic [2:0]  seen_q, seen_d, seen_nx;
  utf8_st_t    u8_q, u8_d, u8_nx;
  logic        high_q, high_d, high_nx;

  // verdict register
  logic       out_valid_q, out_valid_d;
  enc_e       out_enc_q, enc_nx;
  logic [2:0] out_bom_q, bom_nx;
  logic       load_out;

  // handshake: a non-last byte never needs the verdict register, so it always drains
  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && (!s1_last_q || out_free);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc     = in_i.valid && in_i.ready;
  assign load_out   = s1_adv && s1_last_q;

  assign s1_valid_d = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= in_i.data_byte;
      s1_last_q <= in_i.is_last;
    end
  end

  // capture the first four bytes for mark matching, count saturates at four
  always_comb begin
    lead_nx = lead_q;
    seen_nx = seen_q;
    if (seen_q < SEEN_MAX) begin
      for (int i = 0; i < LEAD_BYTES; i++) begin
        if (seen_q == 3'(i)) begin
          lead_nx[8*i +: 8] = s1_byte_q;
        end
      end
      seen_nx = seen_q + 3'd1;
    end
  end

  // any byte above 7f, even past a nul stop
  assign high_nx = high_q || s1_byte_q[7];

  tes_utf8_check u_utf8 (
    .st_i   (u8_q),
    .byte_i (s1_byte_q),
    .st_o   (u8_nx)
  );

  // verdict from the state including the last byte; utf32le is tested before utf16le
  always_comb begin
    enc_nx = ENC_ANSI;
    bom_nx = BOM_NONE;
    if (mark_match(lead_nx, seen_nx, MARK_UTF8, BOM_LEN3)) begin
      enc_nx = ENC_UTF8;
      bom_nx = BOM_LEN3;
    end else if (mark_match(lead_nx, seen_nx, MARK_UTF16BE, BOM_LEN2)) begin
      enc_nx = ENC_UTF16BE;
      bom_nx = BOM_LEN2;
    end else if (mark_match(lead_nx, seen_nx, MARK_UTF32BE, BOM_LEN4)) begin
      enc_nx = ENC_UTF32BE;
      bom_nx = BOM_LEN4;
    end else if (mark_match(lead_nx, seen_nx, MARK_UTF32LE, BOM_LEN4)) begin
      enc_nx = ENC_UTF32LE;
      bom_nx = BOM_LEN4;
    end else if (mark_match(lead_nx, seen_nx, MARK_UTF16LE, BOM_LEN2)) begin
      enc_nx = ENC_UTF16LE;
      bom_nx = BOM_LEN2;
    end else if (mark_match(lead_nx, seen_nx, MARK_SCSU, BOM_LEN3)) begin
      enc_nx = ENC_SCSU;
      bom_nx = BOM_LEN3;
    end else if (mark_match(lead_nx, seen_nx, MARK_BOCU1, BOM_LEN3)) begin
      enc_nx = ENC_BOCU1;
      bom_nx = BOM_LEN3;
    end else if (u8_nx.ok && (u8_nx.nul_stop || (u8_nx.cont_left == 2'd0))) begin
      enc_nx = ENC_UTF8;
    end else if (high_nx) begin
      enc_nx = ENC_WIN1252;
    end
  end

  // state advances with each byte and returns to empty after the last one
  always_comb begin
    lead_d = lead_q;
    seen_d = seen_q;
    u8_d   = u8_q;
    high_d = high_q;
    if (s1_adv) begin
      if (s1_last_q) begin
        lead_d = '0;
        seen_d = '0;
        u8_d   = U8_RESET;
        high_d = 1'b0;
      end else begin
        lead_d = lead_nx;
        seen_d = seen_nx;
        u8_d   = u8_nx;
        high_d = high_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= '0;
      seen_q <= '0;
      u8_q   <= U8_RESET;
      high_q <= 1'b0;
    end else begin
      lead_q <= lead_d;
      seen_q <= seen_d;
      u8_q   <= u8_d;
      high_q <= high_d;
    end
  end

  // verdict register
  assign out_valid_d = load_out ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_enc_q <= enc_nx;
      out_bom_q <= bom_nx;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.encoding   = out_enc_q;
  assign out_o.bom_length = out_bom_q;

  // the byte counter never passes four
  assert property (@(posedge clk_i) disable iff (!rst_ni) seen_q <= SEEN_MAX)
    else $error("byte counter beyond saturation");

  // a last byte leaves an empty buffer behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (seen_q == 3'd0) && (lead_q == 32'd0) && !high_q && (u8_q == U8_RESET))
    else $error("buffer state not cleared after verdict");

  // a verdict only appears from a last byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_last_q))
    else $error("verdict without a last byte");

  // a mark length goes only with a mark encoding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_bom_q != BOM_NONE) |->
      (out_enc_q != ENC_ANSI) && (out_enc_q != ENC_WIN1252))
    else $error("mark length on a markless verdict");

  // a waiting last byte never overwrites a verdict not yet taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !load_out)
    else $error("verdict overwritten");

endmodule
